[hw/rtl/lkvc_pkg.sv]
// shared types and constants for the lru key-value cache
// used by lkvc_cell and lru_key_value_cache; no dependencies
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic             ACT_GET    = 1'b0;
    localparam logic             ACT_SET    = 1'b1;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;
    localparam logic             REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } lkvc_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } lkvc_state_t;

endpackage

[hw/rtl/lkvc_cell.sv]
// one cell of the recency-ordered entry row: holds a key/value pair,
// compares it against the lookup key and loads from its left neighbour
`timescale 1ns / 1ps

module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] lookup_key,
    input  logic             shift_en,
    input  lkvc_entry_t      prev_entry,
    output lkvc_entry_t      entry,
    output logic             match
);

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= prev_entry.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg <= prev_entry.key;
            val_reg <= prev_entry.val;
        end
    end

    assign match       = valid_reg && (key_reg == lookup_key);
    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.val   = val_reg;

endmodule

[hw/rtl/lru_key_value_cache.sv]
// lru key-value cache: a row of cells ordered by recency, cell 0 most recent
// an accepted item passes the compare state, then the update state, which waits while a stall holds the output register
// a compare step over all cells then a shift step per item; the next item is taken as the update step completes
// reset: all entries invalid, occupancy zero, capacity 16; no clearing pass
// depends on lkvc_pkg and lkvc_cell
`timescale 1ns / 1ps

module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // request items
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    action,
    input  logic signed [KEY_W-1:0] key,
    input  logic signed [VAL_W-1:0] value,
    // result items
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    hit,
    output logic signed [VAL_W-1:0] read_value
);

    lkvc_state_t      state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] occ_reg;

    logic             act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    logic             hit_reg;
    logic [VAL_W-1:0] hitval_reg;
    logic [IDX_W-1:0] pos_reg;
    logic             upd_reg;
    logic             grow_reg;

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [VAL_W-1:0] out_value_reg;

    logic             accept;
    logic             upd_fire;
    logic             cfg_write;

    lkvc_entry_t      cell_entry [ENTRIES];
    lkvc_entry_t      cell_prev  [ENTRIES];
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] shift_en;
    logic [ENTRIES-1:0] valid_vec;
    lkvc_entry_t      new_entry;

    logic             any_hit;
    logic [IDX_W-1:0] hit_pos;
    logic [VAL_W-1:0] hit_val;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_eff;
    logic             room;
    logic [CNT_W-1:0] occ_dec;
    logic [IDX_W-1:0] ins_pos;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = 32'(cap_reg);
        end
    end

    // state machine: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_fire)
                begin
                    state_next = in_valid ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state machine: outputs
    always_comb
    begin
        in_stall = 1'b1;
        upd_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_CMP:
            begin
                in_stall = 1'b1;
            end
            ST_UPD:
            begin
                upd_fire = !out_valid_reg || !out_stall;
                in_stall = !upd_fire;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            key_reg <= key;
            val_reg <= value;
        end
    end

    // cell row
    assign new_entry.valid = 1'b1;
    assign new_entry.key   = key_reg;
    assign new_entry.val   = (act_reg == ACT_SET) ? val_reg : hitval_reg;

    genvar j;
    generate
        for (j = 0; j < ENTRIES; j++)
        begin : g_cell
            if (j == 0)
            begin : g_head
                assign cell_prev[j] = new_entry;
            end
            else
            begin : g_link
                assign cell_prev[j] = cell_entry[j-1];
            end

            // cells at or ahead of the touched position move one place back
            assign shift_en[j]  = upd_fire && upd_reg && (pos_reg >= IDX_W'(j));
            assign valid_vec[j] = cell_entry[j].valid;

            lkvc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .lookup_key (key_reg),
                .shift_en   (shift_en[j]),
                .prev_entry (cell_prev[j]),
                .entry      (cell_entry[j]),
                .match      (match[j])
            );
        end
    endgenerate

    // gather the compare results; keys are unique so at most one cell matches
    always_comb
    begin
        hit_pos = '0;
        hit_val = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (match[k])
            begin
                hit_pos = hit_pos | IDX_W'(k);
            end
            hit_val = hit_val | ({VAL_W{match[k]}} & cell_entry[k].val);
        end
    end

    assign any_hit = |match;

    // capacity zero acts as one, and it saturates at the row length
    assign cap_ext = CMP_W'(cap_reg);
    assign cap_eff = (cap_reg == '0) ? CMP_W'(1)
                   : ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
    assign room    = CMP_W'(occ_reg) < cap_eff;
    assign occ_dec = occ_reg - CNT_W'(1);
    // the new item enters cell 0; with room the row shifts into the first empty cell, else the last one drops
    assign ins_pos = room ? occ_reg[IDX_W-1:0] : occ_dec[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CMP)
        begin
            hit_reg    <= any_hit;
            hitval_reg <= hit_val;
            pos_reg    <= any_hit ? hit_pos : ins_pos;
            upd_reg    <= any_hit || (act_reg == ACT_SET);
            grow_reg   <= !any_hit && (act_reg == ACT_SET) && room;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (upd_fire && grow_reg)
        begin
            occ_reg <= occ_reg + CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (upd_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            out_hit_reg <= hit_reg;
            if (act_reg == ACT_GET)
            begin
                out_value_reg <= hit_reg ? hitval_reg : MISS_VALUE;
            end
            else
            begin
                out_value_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign read_value = out_value_reg;

    // checks
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("more than one cell matches the lookup key");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("valid cells disagree with occupancy");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(ENTRIES))
        else $error("occupancy beyond row length");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> out_valid)
        else $error("update without a result item");

endmodule

[tb/tb_lru_key_value_cache.sv]
// self-checking testbench for lru_key_value_cache: directed and random get/set items
// against a recency-ordered shadow of the store, under random request gaps and random result stalls
// depends on lkvc_pkg and the lru_key_value_cache rtl
`timescale 1ns / 1ps

module tb_lru_key_value_cache
    import lkvc_pkg::*;
();

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned LONG_HOLD      = 300;
    localparam logic [2:0]  CAPACITY_ADDR  = {REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] data;
    } reply_t;

    class lru_shadow;
        logic [CAP_W-1:0] capacity;
        logic [KEY_W-1:0] keys [ENTRIES];
        logic [VAL_W-1:0] vals [ENTRIES];
        bit               used [ENTRIES];
        int unsigned      rank [ENTRIES];
        int unsigned      count;
        reply_t           expected_replies[$];
        int unsigned      errors;

        function new();
            capacity = CAP_RESET;
            count    = 0;
            errors   = 0;
            foreach (used[i])
            begin
                used[i] = 0;
                rank[i] = 0;
            end
        endfunction

        function int unsigned eff_cap();
            int unsigned c;
            c = capacity;
            if (c == 0)
                c = 1;
            if (c > ENTRIES)
                c = ENTRIES;
            return c;
        endfunction

        // slot s becomes newest, valid slots newer than limit age by one
        function void make_newest(int s, int unsigned limit);
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (i != s && used[i] && rank[i] < limit)
                    rank[i]++;
            end
            rank[s] = 0;
        endfunction

        function void flag(string what, logic [31:0] exp_word, logic [31:0] got_word);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: expected %h, got %h", $realtime, what, exp_word, got_word);
        endfunction

        function void note_request(logic act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
            int     found;
            int     slot;
            int     oldest;
            bit     any;
            reply_t r;
            found = -1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (used[i] && keys[i] == k)
                begin
                    found = i;
                    break;
                end
            end
            if (found >= 0)
            begin
                make_newest(found, rank[found]);
                r.hit = 1'b1;
                if (act == ACT_GET)
                    r.data = vals[found];
                else
                begin
                    vals[found] = v;
                    r.data      = '0;
                end
            end
            else if (act == ACT_GET)
            begin
                r.hit  = 1'b0;
                r.data = MISS_VALUE;
            end
            else
            begin
                r.hit  = 1'b0;
                r.data = '0;
                slot   = -1;
                if (count < eff_cap())
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!used[i])
                        begin
                            slot = i;
                            break;
                        end
                    end
                end
                if (slot >= 0)
                begin
                    make_newest(slot, 32'hFFFF_FFFF);
                    used[slot] = 1;
                    count++;
                end
                else
                begin
                    // evict the oldest valid entry, occupancy unchanged
                    oldest = 0;
                    any    = 0;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (used[i] && (!any || rank[i] > rank[oldest]))
                        begin
                            oldest = i;
                            any    = 1;
                        end
                    end
                    if (!any)
                    begin
                        oldest  = 0;
                        used[0] = 1;
                        count   = 1;
                        rank[0] = 0;
                    end
                    else
                        make_newest(oldest, rank[oldest]);
                    slot = oldest;
                end
                keys[slot] = k;
                vals[slot] = v;
            end
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic got_hit, logic [VAL_W-1:0] got_data);
            reply_t r;
            if (expected_replies.size() == 0)
            begin
                flag("result with nothing outstanding", '0, {got_hit, got_data[30:0]});
                return;
            end
            r = expected_replies.pop_front();
            if (got_hit !== r.hit)
                flag("hit", 32'(r.hit), 32'(got_hit));
            if (got_data !== r.data)
                flag("read_value", r.data, got_data);
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    logic                    action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
    logic                    out_valid;
    logic                    out_stall;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;

    lru_shadow   shadow = new();
    int unsigned replies_seen = 0;
    int unsigned hold_left    = 0;
    int unsigned idle_cycles  = 0;

    lru_key_value_cache uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .read_value (read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic send_request(input logic act, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v);
        @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shadow.note_request(act, k, v);
    endtask

    task automatic rest_sender(input int unsigned n);
        if (n == 0)
            return;
        @(negedge clk);
        in_valid <= 1'b0;
        action   <= 1'($urandom);
        key      <= $urandom;
        value    <= $urandom;
        repeat (n - 1)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (shadow.expected_replies.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // apb write then read back, only called with the block idle
    task automatic set_capacity(input logic [CAP_W-1:0] c);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= {27'($urandom), c};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        shadow.capacity = c;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(c))
            shadow.flag("capacity read back", 32'(c), prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned n);
        logic [KEY_W-1:0] pool[$];
        int unsigned      psize;
        int unsigned      quiet;
        int unsigned      r;
        logic             act;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        psize = shadow.eff_cap() + $urandom_range(0, shadow.eff_cap() + 2);
        repeat (psize)
            pool.push_back($urandom);
        quiet = 0;
        repeat (n)
        begin
            act = ($urandom_range(0, 99) < 55) ? ACT_SET : ACT_GET;
            r   = $urandom_range(0, 99);
            if (r < 75)
                k = pool[$urandom_range(0, psize - 1)];
            else if (r < 80)
                k = extreme_word();
            else
                k = $urandom;
            v = ($urandom_range(0, 19) == 0) ? extreme_word() : $urandom;
            send_request(act, k, v);
            if (quiet > 0)
                quiet--;
            else if ($urandom_range(0, 59) == 0)
                quiet = $urandom_range(20, 80);
            else
                rest_sender(pick_gap());
        end
    endtask

    // result side: check accepted items, long hold-off twice during the run
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            shadow.check_reply(hit, read_value);
            replies_seen++;
            if (replies_seen == 500 || replies_seen == 1300)
                hold_left = LONG_HOLD;
        end
    end

    initial
    begin
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned n;
        stall_left = 0;
        calm_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 199) == 0)
                    calm_left = $urandom_range(40, 150);
                n = (calm_left > 0) ? 0 : pick_gap();
                if (n > 0)
                begin
                    out_stall  <= 1'b1;
                    stall_left = n - 1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [CAP_W-1:0] phase_caps[10];
        phase_caps = '{5'd16, 5'd1, 5'd0, 5'd4, 5'd31, 5'd2, 5'd9, 5'd17, 5'd3, 5'd16};
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        action    = ACT_GET;
        key       = '0;
        value     = '0;
        out_stall = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty store, extreme keys and values, update on hit, all-ones value on a hit
        send_request(ACT_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(ACT_SET, 32'h8000_0000, 32'h0000_0000);
        send_request(ACT_GET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ACT_SET, 32'h0000_0000, 32'h5555_5555);
        send_request(ACT_SET, 32'h0000_0001, 32'hAAAA_AAAA);
        wait_drained();

        // capacity lowered under the occupancy: old entries still hit, inserts evict
        set_capacity(5'd3);
        send_request(ACT_GET, 32'h7FFF_FFFF, 32'h0);
        send_request(ACT_SET, 32'h0000_002A, 32'h0000_0007);
        send_request(ACT_GET, 32'h8000_0000, 32'h0);
        send_request(ACT_GET, 32'h0000_002A, 32'h0);
        wait_drained();

        // capacity zero acts as one
        set_capacity(5'd0);
        send_request(ACT_SET, 32'h0000_0005, 32'h0000_0005);
        send_request(ACT_SET, 32'h0000_0006, 32'h0000_0006);
        send_request(ACT_GET, 32'h0000_0005, 32'h0);
        send_request(ACT_GET, 32'h0000_0006, 32'h0);
        wait_drained();

        foreach (phase_caps[i])
        begin
            set_capacity(phase_caps[i]);
            run_phase(170);
            wait_drained();
        end

        repeat (10)
            @(posedge clk);
        if (shadow.errors == 0 && shadow.expected_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
